FILE: hw/rtl/sbe_pkg.sv
// Shared types and constants for the stack bytecode execute unit.
// Used by sbe_ctrl, sbe_dpath and the top level; no dependencies.
package sbe_pkg;

  localparam logic [5:0] OP_HALT  = 6'd0;
  localparam logic [5:0] OP_PUSH8 = 6'd1;
  localparam logic [5:0] OP_PUSH16 = 6'd2;
  localparam logic [5:0] OP_PUSH32 = 6'd3;
  localparam logic [5:0] OP_PUSHL = 6'd4;
  localparam logic [5:0] OP_POPL  = 6'd5;
  localparam logic [5:0] OP_JZ    = 6'd6;
  localparam logic [5:0] OP_JNZ   = 6'd7;
  localparam logic [5:0] OP_PJZ   = 6'd8;
  localparam logic [5:0] OP_PJNZ  = 6'd9;
  localparam logic [5:0] OP_JMP   = 6'd10;
  localparam logic [5:0] OP_CALL  = 6'd11;
  localparam logic [5:0] OP_RET   = 6'd12;
  localparam logic [5:0] OP_ISP   = 6'd13;
  localparam logic [5:0] OP_POP   = 6'd14;
  localparam logic [5:0] OP_INC   = 6'd15;
  localparam logic [5:0] OP_DEC   = 6'd16;
  localparam logic [5:0] OP_OR    = 6'd17;
  localparam logic [5:0] OP_XOR   = 6'd18;
  localparam logic [5:0] OP_AND   = 6'd19;
  localparam logic [5:0] OP_EQ    = 6'd20;
  localparam logic [5:0] OP_NE    = 6'd21;
  localparam logic [5:0] OP_LT    = 6'd22;
  localparam logic [5:0] OP_GT    = 6'd23;
  localparam logic [5:0] OP_LE    = 6'd24;
  localparam logic [5:0] OP_GE    = 6'd25;
  localparam logic [5:0] OP_SHL   = 6'd26;
  localparam logic [5:0] OP_SHR   = 6'd27;
  localparam logic [5:0] OP_ADD   = 6'd28;
  localparam logic [5:0] OP_SUB   = 6'd29;
  localparam logic [5:0] OP_MUL   = 6'd30;
  localparam logic [5:0] OP_DIV   = 6'd31;
  localparam logic [5:0] OP_MOD   = 6'd32;
  localparam logic [5:0] OP_LNOT  = 6'd33;
  localparam logic [5:0] OP_BNOT  = 6'd34;
  localparam logic [5:0] OP_NEG   = 6'd35;

  localparam logic [2:0] ST_RUN   = 3'd0;
  localparam logic [2:0] ST_HALT  = 3'd1;
  localparam logic [2:0] ST_UNDER = 3'd2;
  localparam logic [2:0] ST_OVER  = 3'd3;
  localparam logic [2:0] ST_DIVZ  = 3'd4;
  localparam logic [2:0] ST_INVAL = 3'd5;
  localparam logic [2:0] ST_BUILT = 3'd6;
  localparam logic [2:0] ST_CSOVF = 3'd7;

  // Controller to datapath command.
  typedef struct packed {
    logic load;    // latch input beat, set up reads
    logic check;   // evaluate fault checks and read stack operands
    logic exec;    // first execute step
    logic copy;    // one call argument copy step
    logic div_go;  // one divider step
    logic commit;  // write back, form result
  } sbe_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic fault;     // item stops (error or halt) at check
    logic is_call;   // item is a call with arguments to move
    logic is_div;    // item needs the divider
    logic copy_done; // last argument moved
    logic div_done;  // quotient ready
  } sbe_stat_t;

endpackage

FILE: hw/rtl/sbe_ctrl.sv
// Sequencing controller for the stack bytecode execute unit.
// Depends on sbe_pkg for the command and status structs.
module sbe_ctrl
  import sbe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_fire,
  input  logic      out_free,
  input  sbe_stat_t stat,
  output sbe_cmd_t  cmd,
  output logic      busy
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_CHECK = 7'b0000100,
    S_COPY  = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_EXEC  = 7'b0100000,
    S_DONE  = 7'b1000000
  } sbe_state_t;

  sbe_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_CHECK;
      S_CHECK: begin
        cmd.check = 1'b1;
        if (stat.fault) state_nxt = S_DONE;
        else if (stat.is_call) state_nxt = S_COPY;
        else if (stat.is_div) state_nxt = S_DIV;
        else state_nxt = S_EXEC;
      end
      S_COPY: begin
        cmd.copy = 1'b1;
        if (stat.copy_done) state_nxt = S_EXEC;
      end
      S_DIV: begin
        cmd.div_go = 1'b1;
        if (stat.div_done) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("controller state not one-hot");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> state_r == S_IDLE) else $error("load outside idle");
  a_read_next: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |=> state_r == S_CHECK) else $error("read not followed by check");

endmodule

FILE: hw/rtl/sbe_dpath.sv
// Datapath of the stack bytecode execute unit: stacks, pointers, ALU, divider.
// Depends on sbe_pkg; driven by sbe_ctrl commands.
module sbe_dpath
  import sbe_pkg::*;
#(
  parameter int OPERAND_DEPTH = 64,
  parameter int FRAME_DEPTH   = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sbe_cmd_t           cmd,
  input  logic [5:0]         in_action,
  input  logic signed [31:0] in_immediate,
  input  logic signed [16:0] in_target,
  input  logic [7:0]         in_slot,
  input  logic [7:0]         in_arg_count,
  output sbe_stat_t          stat,
  output logic [15:0]        res_next_ip,
  output logic [2:0]         res_status,
  output logic signed [31:0] res_top_value,
  output logic [8:0]         res_depth
);

  localparam int OAW = (OPERAND_DEPTH > 1) ? $clog2(OPERAND_DEPTH) : 1;
  localparam int FAW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
  localparam logic [8:0]  OD9  = 9'(OPERAND_DEPTH);
  localparam logic [17:0] FD18 = 18'(FRAME_DEPTH);

  logic [31:0] ostk [OPERAND_DEPTH];
  logic [31:0] fstk [FRAME_DEPTH];

  // Architectural state.
  logic [8:0]  cnt_r;
  logic [15:0] ftop_r, fbase_r, ip_r;
  logic [2:0]  stop_r;
  logic [31:0] bottom_r; // mirror of operand entry 0 for the halt report

  // Latched beat.
  logic [5:0]  act_r;
  logic [31:0] imm_r;
  logic [16:0] tgt_r;
  logic [7:0]  slot_r, args_r;

  // Operands read from memories.
  logic [31:0] a_r, b_r, loc_r, sv0_r, sv1_r;
  logic [2:0]  code_r;   // fault code found at check (ST_RUN when none)
  logic [8:0]  ci_r;     // copy index, runs 0..arg_count+1
  logic [31:0] cdat_r;   // copy data pipeline
  logic        cval_r;
  logic [FAW-1:0] cwa_r;

  // Read address registers (registered read memories).
  logic [OAW-1:0] ora_r, orb_r;
  logic [FAW-1:0] fra_r, frb_r;
  logic [31:0]    ord_a_r, ord_b_r, frd_a_r, frd_b_r;

  logic [17:0] local_w;
  logic        local_ok;
  assign local_w  = 18'(fbase_r) + 18'(slot_r);
  assign local_ok = local_w < FD18;

  // Read address selection: on load, compute from the incoming beat.
  logic [17:0] lw_in;
  assign lw_in = 18'(fbase_r) + 18'(in_slot);

  // Address arithmetic, truncated to the memory index width where used.
  logic [8:0]  cnt_m1, cnt_m2, cnt_ma;
  logic [17:0] fb_m1, fb_m2, ft_m1;
  assign cnt_m1 = cnt_r - 9'd1;
  assign cnt_m2 = cnt_r - 9'd2;
  assign cnt_ma = cnt_r - 9'(args_r);
  assign fb_m1  = 18'(fbase_r) - 18'd1;
  assign fb_m2  = 18'(fbase_r) - 18'd2;
  assign ft_m1  = 18'(ftop_r) - 18'd1;

  always_ff @(posedge clk) begin
    ord_a_r <= ostk[ora_r];
    ord_b_r <= ostk[orb_r];
    frd_a_r <= fstk[fra_r];
    frd_b_r <= fstk[frb_r];
  end

  // Divider: restoring, one quotient bit a cycle on magnitudes.
  logic [31:0] dq_r, dr_r, dd_r;
  logic [5:0]  dn_r;
  logic [32:0] dtrial;
  assign dtrial = {dr_r, dq_r[31]} - {1'b0, dd_r};

  // Check-stage evaluation.
  logic [2:0] chk;
  logic       is_call, is_div;
  logic [17:0] cbase;
  logic [17:0] cwa_w;
  assign cbase = 18'(ftop_r) + 18'd2;
  assign cwa_w = cbase + 18'(ci_r) - 18'd1;
  always_comb begin
    chk = ST_RUN;
    is_call = 1'b0;
    is_div = 1'b0;
    if (stop_r != ST_RUN) chk = stop_r;
    else begin
      case (act_r)
        OP_HALT: chk = ST_HALT;
        OP_PUSH8, OP_PUSH16, OP_PUSH32: if (cnt_r >= OD9) chk = ST_OVER;
        OP_PUSHL: begin
          if (cnt_r >= OD9) chk = ST_OVER;
          else if (!local_ok) chk = ST_CSOVF;
        end
        OP_POPL: begin
          if (cnt_r < 9'd1 || cnt_r > OD9) chk = ST_UNDER;
          else if (!local_ok) chk = ST_CSOVF;
        end
        OP_JZ, OP_JNZ, OP_PJZ, OP_PJNZ, OP_POP:
          if (cnt_r < 9'd1 || cnt_r > OD9) chk = ST_UNDER;
        OP_JMP: chk = ST_RUN;
        OP_CALL: begin
          if (9'(args_r) > cnt_r || cnt_r > OD9) chk = ST_UNDER;
          else if (tgt_r[16]) chk = ST_BUILT;
          else if (cbase + 18'(args_r) > FD18 || cbase > 18'hFFFF) chk = ST_CSOVF;
          else is_call = 1'b1;
        end
        OP_RET: begin
          if (fbase_r < 16'd2) chk = ST_UNDER;
          else if (18'(fbase_r) - 18'd1 >= FD18) chk = ST_CSOVF;
        end
        OP_ISP:
          if (18'(ftop_r) + 18'(slot_r) > FD18 || 18'(ftop_r) + 18'(slot_r) > 18'hFFFF)
            chk = ST_CSOVF;
        OP_INC, OP_DEC: if (!local_ok) chk = ST_CSOVF;
        OP_LNOT, OP_BNOT, OP_NEG:
          if (cnt_r < 9'd1 || cnt_r > OD9) chk = ST_UNDER;
        default: begin
          if (act_r > OP_NEG) chk = ST_INVAL;
          else if (cnt_r < 9'd2 || cnt_r > OD9) chk = ST_UNDER;
          else if ((act_r == OP_DIV || act_r == OP_MOD) && ord_b_r == 32'd0) chk = ST_DIVZ;
          else if (act_r == OP_DIV || act_r == OP_MOD) is_div = 1'b1;
        end
      endcase
    end
  end

  assign stat.fault     = (chk != ST_RUN);
  assign stat.is_call   = is_call;
  assign stat.is_div    = is_div;
  assign stat.copy_done = (ci_r == 9'(args_r) + 9'd1);
  assign stat.div_done  = (dn_r == 6'd32);

  // ALU and division result selection (a below top, b top).
  logic [31:0] alu_y;
  logic [4:0]  sh;
  assign sh = b_r[4:0];
  logic [31:0] qs, rs;
  assign qs = (a_r[31] ^ b_r[31]) ? (32'd0 - dq_r) : dq_r;
  assign rs = a_r[31] ? (32'd0 - dr_r) : dr_r;
  always_comb begin
    case (act_r)
      OP_OR:  alu_y = a_r | b_r;
      OP_XOR: alu_y = a_r ^ b_r;
      OP_AND: alu_y = a_r & b_r;
      OP_EQ:  alu_y = {31'd0, a_r == b_r};
      OP_NE:  alu_y = {31'd0, a_r != b_r};
      OP_LT:  alu_y = {31'd0, $signed(a_r) < $signed(b_r)};
      OP_GT:  alu_y = {31'd0, $signed(a_r) > $signed(b_r)};
      OP_LE:  alu_y = {31'd0, $signed(a_r) <= $signed(b_r)};
      OP_GE:  alu_y = {31'd0, $signed(a_r) >= $signed(b_r)};
      OP_SHL: alu_y = a_r << sh;
      OP_SHR: alu_y = $unsigned($signed(a_r) >>> sh);
      OP_ADD: alu_y = a_r + b_r;
      OP_SUB: alu_y = a_r - b_r;
      OP_MUL: alu_y = a_r * b_r;
      OP_DIV: alu_y = qs;
      OP_MOD: alu_y = rs;
      OP_LNOT: alu_y = {31'd0, b_r == 32'd0};
      OP_BNOT: alu_y = ~b_r;
      OP_NEG:  alu_y = 32'd0 - b_r;
      default: alu_y = 32'd0;
    endcase
  end

  // Single write ports, driven in exec (and copy and commit for the frame store).
  logic           ow_en, fw_en, fw2_en;
  logic [OAW-1:0] ow_a;
  logic [FAW-1:0] fw_a;
  logic [31:0]    ow_d, fw_d;
  logic [15:0]    ip_new, ftop_new, fbase_new;
  logic [8:0]     cnt_new, cnt_new_m1;
  logic           take;

  assign cnt_new_m1 = cnt_new - 9'd1;

  always_comb begin
    ow_en = 1'b0; fw_en = 1'b0; fw2_en = 1'b0;
    ow_a = cnt_r[OAW-1:0]; ow_d = imm_r;
    fw_a = local_w[FAW-1:0]; fw_d = a_r;
    ip_new = ip_r; ftop_new = ftop_r; fbase_new = fbase_r; cnt_new = cnt_r;
    take = 1'b0;
    case (act_r)
      OP_PUSH8, OP_PUSH16, OP_PUSH32: begin
        ow_en = 1'b1;
        cnt_new = cnt_r + 9'd1;
        ip_new = ip_r + ((act_r == OP_PUSH8) ? 16'd2 : (act_r == OP_PUSH16) ? 16'd3 : 16'd5);
      end
      OP_PUSHL: begin
        ow_en = 1'b1; ow_d = loc_r;
        cnt_new = cnt_r + 9'd1; ip_new = ip_r + 16'd2;
      end
      OP_POPL: begin
        fw_en = 1'b1; fw_d = b_r;
        cnt_new = cnt_r - 9'd1; ip_new = ip_r + 16'd2;
      end
      OP_JZ, OP_JNZ, OP_PJZ, OP_PJNZ: begin
        take = (act_r == OP_JZ || act_r == OP_PJZ) ? (b_r == 32'd0) : (b_r != 32'd0);
        if (act_r <= OP_JNZ || !take) cnt_new = cnt_r - 9'd1;
        ip_new = take ? tgt_r[15:0] : ip_r + 16'd3;
      end
      OP_JMP: ip_new = tgt_r[15:0];
      OP_CALL: begin
        fw_en = 1'b1; fw_a = ftop_r[FAW-1:0]; fw_d = {16'd0, ip_r + 16'd4};
        fw2_en = 1'b1;
        cnt_new = cnt_r - 9'(args_r);
        fbase_new = ftop_r + 16'd2; ftop_new = ftop_r + 16'd2;
        ip_new = tgt_r[15:0];
      end
      OP_RET: begin
        ftop_new = fbase_r - 16'd2;
        ip_new = sv0_r[15:0];
        fbase_new = sv1_r[15:0];
      end
      OP_ISP: begin
        ftop_new = ftop_r + 16'(slot_r); ip_new = ip_r + 16'd2;
      end
      OP_POP: begin
        cnt_new = cnt_r - 9'd1; ip_new = ip_r + 16'd1;
      end
      OP_INC, OP_DEC: begin
        fw_en = 1'b1;
        fw_d = (act_r == OP_INC) ? loc_r + 32'd1 : loc_r - 32'd1;
        ip_new = ip_r + 16'd2;
      end
      OP_LNOT, OP_BNOT, OP_NEG: begin
        ow_en = 1'b1; ow_a = cnt_m1[OAW-1:0]; ow_d = alu_y;
        ip_new = ip_r + 16'd1;
      end
      default: begin
        ow_en = 1'b1; ow_a = cnt_m2[OAW-1:0]; ow_d = alu_y;
        cnt_new = cnt_r - 9'd1; ip_new = ip_r + 16'd1;
      end
    endcase
  end

  logic [16:0] saved_link;
  assign saved_link = {1'b0, fbase_r};

  // Memory writes. The call's second link entry (old frame base, just below
  // the new base) goes in the commit cycle; argument copies drain before exec.
  always_ff @(posedge clk) begin
    if (cmd.exec && ow_en) ostk[ow_a] <= ow_d;
    if (cmd.exec && fw_en) fstk[fw_a] <= fw_d;
    else if (cval_r) fstk[cwa_r] <= cdat_r;
    else if (cmd.commit && code_r == ST_RUN && act_r == OP_CALL && fw2_en)
      fstk[ft_m1[FAW-1:0]] <= {16'd0, saved_link[15:0]};
  end

  // Control and payload registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; ftop_r <= '0; fbase_r <= '0; ip_r <= '0; stop_r <= ST_RUN;
      cval_r <= 1'b0;
    end else begin
      // copy index 1..arg_count has entry index-1 on the read data
      cval_r <= cmd.copy && ci_r != 9'd0 && ci_r <= 9'(args_r);
      if (cmd.check && chk != ST_RUN) stop_r <= chk;
      if (cmd.exec) begin
        cnt_r <= cnt_new; ip_r <= ip_new; ftop_r <= ftop_new;
        fbase_r <= (act_r == OP_CALL) ? fbase_r : fbase_new;
      end
      if (cmd.commit && code_r == ST_RUN && act_r == OP_CALL) fbase_r <= ftop_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_action; imm_r <= in_immediate; tgt_r <= in_target;
      slot_r <= in_slot; args_r <= in_arg_count; ci_r <= '0;
      ora_r <= cnt_m2[OAW-1:0];
      orb_r <= cnt_m1[OAW-1:0];
      fra_r <= (in_action == OP_RET) ? fb_m2[FAW-1:0] : lw_in[FAW-1:0];
      frb_r <= fb_m1[FAW-1:0];
    end
    if (cmd.check) begin
      a_r <= ord_a_r; b_r <= ord_b_r; loc_r <= frd_a_r;
      sv0_r <= frd_a_r; sv1_r <= frd_b_r; code_r <= chk;
      ora_r <= cnt_ma[OAW-1:0];
      // divider setup on magnitudes
      dq_r <= ord_a_r[31] ? 32'd0 - ord_a_r : ord_a_r;
      dd_r <= ord_b_r[31] ? 32'd0 - ord_b_r : ord_b_r;
      dr_r <= '0; dn_r <= '0;
    end
    if (cmd.copy && !stat.copy_done) begin
      // stack read registered: address advances, data lands on the next cycle
      ci_r <= ci_r + 9'd1;
      ora_r <= ora_r + OAW'(1);
    end
    // after exec the second read port follows the new top of stack
    if (cmd.exec) orb_r <= cnt_new_m1[OAW-1:0];
    cdat_r <= ord_a_r;
    cwa_r <= cwa_w[FAW-1:0];
    if (cmd.div_go && dn_r != 6'd32) begin
      dn_r <= dn_r + 6'd1;
      if (!dtrial[32]) begin
        dr_r <= dtrial[31:0]; dq_r <= {dq_r[30:0], 1'b1};
      end else begin
        dr_r <= {dr_r[30:0], dq_r[31]}; dq_r <= {dq_r[30:0], 1'b0};
      end
    end
    if (cmd.exec && ow_en && ow_a == '0) bottom_r <= ow_d;
  end

  // Result: top of stack comes from the second read port once exec has set orb_r
  // and ord_b_r has read it (or unchanged since load for a faulted or stopped item).
  assign res_next_ip   = ip_r;
  assign res_status    = stop_r;
  assign res_depth     = cnt_r;
  assign res_top_value = (stop_r == ST_HALT) ? bottom_r :
                         (cnt_r != 9'd0 && cnt_r <= OD9) ? ord_b_r : 32'd0;

  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(stop_r) != ST_RUN |-> stop_r == $past(stop_r)) else $error("stop code changed");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= OD9) else $error("operand count beyond depth");
  a_fault_noexec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.check && stat.fault |=> !cmd.exec) else $error("faulted item executed");

endmodule

FILE: hw/rtl/stack_bytecode_execute_unit.sv
// Stack bytecode execute unit, top level: controller plus datapath and result register.
// Depends on sbe_pkg, sbe_ctrl and sbe_dpath.
// Items run one at a time through the read/check/execute sequence, with no overlap.
// Reset (rst_n low, synchronous) clears counters, pointers and the stop code; the
// stacks are not cleared and entries are undefined until written.
module stack_bytecode_execute_unit
  import sbe_pkg::*;
#(
  parameter int OPERAND_DEPTH = 64,
  parameter int FRAME_DEPTH   = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [5:0]         in_action,
  input  logic signed [31:0] in_immediate,
  input  logic signed [16:0] in_target,
  input  logic [7:0]         in_slot,
  input  logic [7:0]         in_arg_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_next_ip,
  output logic [2:0]         out_status,
  output logic signed [31:0] out_top_value,
  output logic [8:0]         out_depth
);

  sbe_cmd_t  cmd;
  sbe_stat_t stat;
  logic      busy, out_free, commit_d_r;
  logic [15:0] r_ip;
  logic [2:0]  r_st;
  logic signed [31:0] r_top;
  logic [8:0]  r_dep;

  assign in_ready = !busy;
  assign out_free = !out_valid || out_ready;

  sbe_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_valid && in_ready),
    .out_free(out_free && !commit_d_r), .stat(stat), .cmd(cmd), .busy(busy)
  );

  sbe_dpath #(.OPERAND_DEPTH(OPERAND_DEPTH), .FRAME_DEPTH(FRAME_DEPTH)) u_dpath (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .in_action(in_action), .in_immediate(in_immediate), .in_target(in_target),
    .in_slot(in_slot), .in_arg_count(in_arg_count), .stat(stat),
    .res_next_ip(r_ip), .res_status(r_st), .res_top_value(r_top), .res_depth(r_dep)
  );

  // Result register: captured in the cycle after commit so the top-of-stack read settles.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0; commit_d_r <= 1'b0;
    end else begin
      commit_d_r <= cmd.commit;
      if (commit_d_r) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_d_r) begin
      out_next_ip <= r_ip; out_status <= r_st;
      out_top_value <= r_top; out_depth <= r_dep;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result beat dropped");
  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("second beat taken while busy");
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !out_valid || out_ready) else $error("commit over waiting result");

endmodule
